### sv/sme_pkg.sv
// Package for the stack machine executor: opcode and status codes, queue entry type.
// No dependencies.
package sme_pkg;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'd0,
        OP_PALL  = 4'd1,
        OP_PINT  = 4'd2,
        OP_POP   = 4'd3,
        OP_SWAP  = 4'd4,
        OP_ADD   = 4'd5,
        OP_NOP   = 4'd6,
        OP_SUB   = 4'd7,
        OP_DIV   = 4'd8,
        OP_MOD   = 4'd9,
        OP_MUL   = 4'd10,
        OP_PCHAR = 4'd11,
        OP_PSTR  = 4'd12,
        OP_ROTL  = 4'd13,
        OP_ROTR  = 4'd14,
        OP_BAD   = 4'd15
    } t_op;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_SHORT = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_RANGE = 3'd4,
        ST_UNK   = 3'd5,
        ST_FULL  = 3'd6
    } t_status;

    localparam logic [31:0] CHAR_MAX = 32'd126;

    typedef struct packed {
        t_op         op;
        logic [31:0] operand;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_LIST, S_LISTW,
        S_ROT, S_ROTW, S_ROTF, S_WB, S_DONE
    } t_state;

endpackage

### sv/sme_front.sv
// Front end: accepts commands and holds them in a two-entry queue for the back end.
// Depends on sme_pkg.
module sme_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [3:0]        i_command,
    input  logic [31:0]       i_operand,
    output logic              o_busy,
    output logic              o_q_valid,
    output sme_pkg::t_cmd     o_q_data,
    input  logic              i_q_pop
);
    sme_pkg::t_cmd r_q [2];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          r_wr;
    logic          push;

    assign o_busy    = (r_cnt == 2'd2);
    assign push      = i_start && !o_busy;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{op: sme_pkg::t_op'(i_command), operand: i_operand};
        end
    end
endmodule

### sv/sme_div.sv
// Signed restoring divider, one quotient bit per cycle; truncating quotient and remainder.
// No dependencies.
module sme_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [31:0] o_rem
);
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_d;
    logic [5:0]  r_n;
    logic        r_run;
    logic        r_qn;
    logic        r_rn;
    logic [32:0] trial;

    assign trial  = {r_r, r_q[31]} - {1'b0, r_d};
    assign o_done = r_run && (r_n == 6'd0);
    assign o_quo  = r_qn ? (32'd0 - r_q) : r_q;
    assign o_rem  = r_rn ? (32'd0 - r_r) : r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_n   <= 6'd0;
        end else if (i_go) begin
            r_run <= 1'b1;
            r_n   <= 6'd32;
        end else if (r_run) begin
            if (r_n == 6'd0) begin
                r_run <= 1'b0;
            end else begin
                r_n <= r_n - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q  <= i_a[31] ? (32'd0 - i_a) : i_a;
            r_d  <= i_b[31] ? (32'd0 - i_b) : i_b;
            r_r  <= 32'd0;
            r_qn <= i_a[31] ^ i_b[31];
            r_rn <= i_a[31];
        end else if (r_run && r_n != 6'd0) begin
            if (!trial[32]) begin
                r_r <= trial[31:0];
                r_q <= {r_q[30:0], 1'b1};
            end else begin
                r_r <= {r_r[30:0], r_q[31]};
                r_q <= {r_q[30:0], 1'b0};
            end
        end
    end
endmodule

### sv/sme_back.sv
// Back end: stack memory and sequencer that carries out one queued command at a time.
// Depends on sme_pkg and sme_div.
module sme_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sme_pkg::t_cmd i_q_data,
    output logic          o_q_pop,
    output logic          o_valid,
    output logic [2:0]    o_status,
    output logic          o_has_value,
    output logic [31:0]   o_value,
    output logic          o_last
);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0]        r_mem [STACK_DEPTH];
    logic [31:0]        r_rdata;
    sme_pkg::t_state    r_state, n_state;
    sme_pkg::t_cmd      r_cmd;
    logic [5:0]         r_cnt;
    logic [5:0]         r_idx;
    logic [31:0]        r_b;
    logic [31:0]        r_a;
    logic [31:0]        r_res;
    logic [2:0]         r_st;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [AW-1:0]      raddr;
    logic               div_go;
    logic               div_done;
    logic [31:0]        quo;
    logic [31:0]        rem;
    logic               lst_stop;

    // dividend is still on the read port when the divider starts
    sme_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (div_go),
        .i_a    (r_rdata),
        .i_b    (r_b),
        .o_done (div_done),
        .o_quo  (quo),
        .o_rem  (rem)
    );

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign lst_stop = (r_cmd.op == sme_pkg::OP_PSTR)
                      && (r_rdata == 32'd0 || r_rdata > sme_pkg::CHAR_MAX);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sme_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = sme_pkg::S_RD1;
                end
            end
            sme_pkg::S_RD1: begin
                unique case (r_cmd.op) inside
                    sme_pkg::OP_PALL, sme_pkg::OP_PSTR: begin
                        n_state = (r_cnt == 6'd0) ? sme_pkg::S_DONE : sme_pkg::S_LISTW;
                    end
                    sme_pkg::OP_ROTL, sme_pkg::OP_ROTR: begin
                        n_state = (r_cnt < 6'd2) ? sme_pkg::S_DONE : sme_pkg::S_ROTW;
                    end
                    sme_pkg::OP_SWAP, sme_pkg::OP_ADD, sme_pkg::OP_SUB,
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD, sme_pkg::OP_MUL: begin
                        n_state = (r_cnt < 6'd2) ? sme_pkg::S_DONE : sme_pkg::S_RD2;
                    end
                    sme_pkg::OP_PINT, sme_pkg::OP_PCHAR: begin
                        n_state = (r_cnt == 6'd0) ? sme_pkg::S_DONE : sme_pkg::S_RD2;
                    end
                    default: n_state = sme_pkg::S_DONE;
                endcase
            end
            sme_pkg::S_RD2: n_state = sme_pkg::S_EXEC;
            sme_pkg::S_EXEC: begin
                unique case (r_cmd.op) inside
                    sme_pkg::OP_PINT: n_state = sme_pkg::S_IDLE;
                    sme_pkg::OP_PCHAR: begin
                        n_state = (r_b > sme_pkg::CHAR_MAX) ? sme_pkg::S_DONE
                                                            : sme_pkg::S_IDLE;
                    end
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                        n_state = (r_b == 32'd0) ? sme_pkg::S_DONE : sme_pkg::S_DIV;
                    end
                    default: n_state = sme_pkg::S_WB;
                endcase
            end
            sme_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = sme_pkg::S_WB;
                end
            end
            sme_pkg::S_WB: n_state = sme_pkg::S_DONE;
            sme_pkg::S_LISTW: n_state = sme_pkg::S_LIST;
            sme_pkg::S_LIST: begin
                if (lst_stop || r_idx == 6'd1) begin
                    n_state = sme_pkg::S_DONE;
                end else begin
                    n_state = sme_pkg::S_LISTW;
                end
            end
            sme_pkg::S_ROTW: n_state = sme_pkg::S_ROT;
            sme_pkg::S_ROT: begin
                if (r_idx == 6'd2) begin
                    n_state = sme_pkg::S_ROTF;
                end else begin
                    n_state = sme_pkg::S_ROTW;
                end
            end
            sme_pkg::S_ROTF: n_state = sme_pkg::S_DONE;
            sme_pkg::S_DONE: n_state = sme_pkg::S_IDLE;
            default: n_state = sme_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop     = 1'b0;
        o_valid     = 1'b0;
        o_status    = sme_pkg::ST_OK;
        o_has_value = 1'b0;
        o_value     = 32'd0;
        o_last      = 1'b0;
        we          = 1'b0;
        waddr       = '0;
        wdata       = r_res;
        raddr       = AW'(r_cnt - 6'd1);
        div_go      = 1'b0;
        unique case (r_state)
            sme_pkg::S_IDLE: o_q_pop = i_q_valid;
            sme_pkg::S_RD1: begin
                raddr = AW'(r_cnt - 6'd1);
                if (r_cmd.op == sme_pkg::OP_ROTR) begin
                    raddr = '0;
                end
                if (r_cmd.op == sme_pkg::OP_PUSH && r_cnt < 6'(STACK_DEPTH)) begin
                    we    = 1'b1;
                    waddr = AW'(r_cnt);
                    wdata = r_cmd.operand;
                end
            end
            sme_pkg::S_RD2: raddr = AW'(r_cnt - 6'd2);
            sme_pkg::S_EXEC: begin
                if (r_cmd.op == sme_pkg::OP_PINT
                    || (r_cmd.op == sme_pkg::OP_PCHAR && r_b <= sme_pkg::CHAR_MAX)) begin
                    o_valid     = 1'b1;
                    o_has_value = 1'b1;
                    o_value     = r_b;
                    o_last      = 1'b1;
                end
                div_go = (r_cmd.op == sme_pkg::OP_DIV || r_cmd.op == sme_pkg::OP_MOD)
                         && r_b != 32'd0;
            end
            sme_pkg::S_WB: begin
                we = 1'b1;
                if (r_cmd.op == sme_pkg::OP_SWAP) begin
                    waddr = AW'(r_cnt - 6'd2);
                    wdata = r_b;
                end else begin
                    waddr = AW'(r_cnt - 6'd2);
                    wdata = r_res;
                end
            end
            sme_pkg::S_LISTW: raddr = AW'(r_idx - 6'd1);
            sme_pkg::S_LIST: begin
                if (!lst_stop) begin
                    o_valid     = 1'b1;
                    o_has_value = 1'b1;
                    o_value     = r_rdata;
                end
            end
            sme_pkg::S_ROTW: begin
                if (r_cmd.op == sme_pkg::OP_ROTL) begin
                    raddr = AW'(r_idx - 6'd2);
                end else begin
                    raddr = AW'(r_cnt - r_idx + 6'd1);
                end
            end
            sme_pkg::S_ROT: begin
                we = 1'b1;
                if (r_cmd.op == sme_pkg::OP_ROTL) begin
                    waddr = AW'(r_idx - 6'd1);
                end else begin
                    waddr = AW'(r_cnt - r_idx);
                end
                wdata = r_rdata;
            end
            sme_pkg::S_ROTF: begin
                we    = 1'b1;
                waddr = (r_cmd.op == sme_pkg::OP_ROTL) ? '0 : AW'(r_cnt - 6'd1);
                wdata = r_a;
            end
            sme_pkg::S_DONE: begin
                o_valid  = 1'b1;
                o_status = r_st;
                o_last   = 1'b1;
                // second half of swap: old second word goes on top
                if (r_cmd.op == sme_pkg::OP_SWAP && r_st == sme_pkg::ST_OK) begin
                    we    = 1'b1;
                    waddr = AW'(r_cnt - 6'd1);
                    wdata = r_a;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sme_pkg::S_IDLE;
            r_cnt   <= 6'd0;
        end else begin
            r_state <= n_state;
            if (r_state == sme_pkg::S_RD1 && r_cmd.op == sme_pkg::OP_PUSH
                && r_cnt < 6'(STACK_DEPTH)) begin
                r_cnt <= r_cnt + 6'd1;
            end
            if (r_state == sme_pkg::S_RD1 && r_cmd.op == sme_pkg::OP_POP
                && r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
            if (r_state == sme_pkg::S_WB && r_cmd.op != sme_pkg::OP_SWAP) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sme_pkg::S_IDLE: begin
                r_cmd <= i_q_data;
                r_st  <= sme_pkg::ST_OK;
            end
            sme_pkg::S_RD1: begin
                r_idx <= r_cnt;
                case (r_cmd.op) inside
                    sme_pkg::OP_PUSH:
                        if (r_cnt >= 6'(STACK_DEPTH)) r_st <= sme_pkg::ST_FULL;
                    sme_pkg::OP_PINT, sme_pkg::OP_PCHAR, sme_pkg::OP_POP:
                        if (r_cnt == 6'd0) r_st <= sme_pkg::ST_EMPTY;
                    sme_pkg::OP_SWAP, sme_pkg::OP_ADD, sme_pkg::OP_SUB,
                    sme_pkg::OP_DIV, sme_pkg::OP_MOD, sme_pkg::OP_MUL:
                        if (r_cnt < 6'd2) r_st <= sme_pkg::ST_SHORT;
                    sme_pkg::OP_BAD: r_st <= sme_pkg::ST_UNK;
                    default: ;
                endcase
            end
            sme_pkg::S_RD2: r_b <= r_rdata;
            sme_pkg::S_EXEC: begin
                r_a <= r_rdata;
                if (r_cmd.op == sme_pkg::OP_PCHAR && r_b > sme_pkg::CHAR_MAX) begin
                    r_st <= sme_pkg::ST_RANGE;
                end
                if ((r_cmd.op == sme_pkg::OP_DIV || r_cmd.op == sme_pkg::OP_MOD)
                    && r_b == 32'd0) begin
                    r_st <= sme_pkg::ST_DIVZ;
                end
            end
            sme_pkg::S_DIV: r_res <= (r_cmd.op == sme_pkg::OP_DIV) ? quo : rem;
            sme_pkg::S_LIST: r_idx <= r_idx - 6'd1;
            sme_pkg::S_ROTW: begin
                if (r_idx == r_cnt || (r_cmd.op == sme_pkg::OP_ROTR && r_idx == r_cnt)) begin
                    r_a <= r_rdata;
                end
            end
            sme_pkg::S_ROT: r_idx <= r_idx - 6'd1;
            default: ;
        endcase
        if (r_state == sme_pkg::S_EXEC) begin
            unique case (r_cmd.op) inside
                sme_pkg::OP_ADD: r_res <= r_rdata + r_b;
                sme_pkg::OP_SUB: r_res <= r_rdata - r_b;
                sme_pkg::OP_MUL: r_res <= r_rdata * r_b;
                default: ;
            endcase
        end
        if (r_state == sme_pkg::S_WB) begin
            r_res <= r_res;
        end
    end
endmodule

### sv/stack_machine_execute.sv
// Stack machine executor: one decoded opcode per command on a bounded word stack.
// Depends on sme_pkg, sme_front, sme_back.
//
// Channels: a command (i_command, i_operand) transfers at a clock edge with
// start high and busy low. A two-entry queue holds commands for the
// back end, so busy rises only when both slots are taken.
// Results come out at most one per cycle on o_status, o_has_value, o_value
// and o_last, marked by o_valid; o_last closes each command. The receiver
// cannot stall the block.
// Sequencing: push, pop, nop and early errors go from S_RD1 to S_DONE;
// pint and pchar answer from S_EXEC; swap, add, sub and mul go on via S_WB.
// Division and remainder wait in S_DIV on the one-bit-per-cycle divider.
// Listings go S_LISTW, S_LIST per word (one stack memory read port); rotations
// go S_ROTW, S_ROT per entry moved. Commands run one at a time in the back end.
// Reset: synchronous, active low; empties the stack and the queue. The
// stack memory itself is not cleared.
module stack_machine_execute #(
    parameter int STACK_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_command,
    input  logic [31:0] i_operand,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_has_value,
    output logic [31:0] o_value,
    output logic        o_last
);
    logic          q_valid;
    logic          q_pop;
    sme_pkg::t_cmd q_data;

    sme_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_command(i_command),
        .i_operand(i_operand),
        .o_busy   (busy),
        .o_q_valid(q_valid),
        .o_q_data (q_data),
        .i_q_pop  (q_pop)
    );

    sme_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_has_value(o_has_value),
        .o_value    (o_value),
        .o_last     (o_last)
    );
endmodule

### tb/tb.sv
// Self-checking testbench for stack_machine_execute: a directed table, a fill-to-full
// run and then random command sequences, each checked against a behavioural stack
// model kept in the bench. Depends on sme_pkg and the stack_machine_execute RTL.
module tb;

    localparam int DEPTH     = 32;
    localparam int N_RANDOM  = 235;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        sme_pkg::t_status status;
        logic             has_value;
        logic [31:0]      value;
        logic             last;
    } t_res;

    typedef struct {
        sme_pkg::t_op     op;
        logic [31:0]      operand;
        logic             typed;
        sme_pkg::t_status exp_status;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  i_command;
    logic [31:0] i_operand;
    logic        o_valid;
    logic [2:0]  o_status;
    logic        o_has_value;
    logic [31:0] o_value;
    logic        o_last;

    logic [31:0] words[DEPTH];
    int          n_words;
    t_res        pending[$];
    t_row        table_rows[$];
    int          n_fail;
    int          n_results;
    int          n_cmds;
    int          cycles;

    stack_machine_execute #(.STACK_DEPTH(DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_command(i_command), .i_operand(i_operand), .o_valid(o_valid),
        .o_status(o_status), .o_has_value(o_has_value), .o_value(o_value),
        .o_last(o_last)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_res mk(sme_pkg::t_status s, logic hv, logic [31:0] v, logic l);
        t_res r;
        r.status = s;
        r.has_value = hv;
        r.value = v;
        r.last = l;
        return r;
    endfunction

    function automatic logic [31:0] mag(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // advance the stack copy by one command, queueing the expected items
    task automatic execute_cmd(sme_pkg::t_op op, logic [31:0] opnd);
        sme_pkg::t_status st;
        logic [31:0]      a, b, r, t;
        int               i;
        st = sme_pkg::ST_OK;
        case (op)
            sme_pkg::OP_PUSH: begin
                if (n_words >= DEPTH) st = sme_pkg::ST_FULL;
                else begin
                    words[n_words] = opnd;
                    n_words++;
                end
            end
            sme_pkg::OP_PALL, sme_pkg::OP_PSTR: begin
                for (i = n_words - 1; i >= 0; i--) begin
                    if (op == sme_pkg::OP_PSTR
                        && (words[i] == 0 || words[i] > sme_pkg::CHAR_MAX)) break;
                    pending.push_back(mk(sme_pkg::ST_OK, 1'b1, words[i], 1'b0));
                end
                pending.push_back(mk(sme_pkg::ST_OK, 1'b0, 32'd0, 1'b1));
                return;
            end
            sme_pkg::OP_PINT, sme_pkg::OP_PCHAR: begin
                if (n_words == 0) st = sme_pkg::ST_EMPTY;
                else if (op == sme_pkg::OP_PCHAR && words[n_words-1] > sme_pkg::CHAR_MAX)
                    st = sme_pkg::ST_RANGE;
                else begin
                    pending.push_back(mk(sme_pkg::ST_OK, 1'b1, words[n_words-1], 1'b1));
                    return;
                end
            end
            sme_pkg::OP_POP: begin
                if (n_words == 0) st = sme_pkg::ST_EMPTY;
                else n_words--;
            end
            sme_pkg::OP_SWAP: begin
                if (n_words < 2) st = sme_pkg::ST_SHORT;
                else begin
                    t = words[n_words-1];
                    words[n_words-1] = words[n_words-2];
                    words[n_words-2] = t;
                end
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
            sme_pkg::OP_DIV, sme_pkg::OP_MOD: begin
                if (n_words < 2) st = sme_pkg::ST_SHORT;
                else begin
                    b = words[n_words-1];
                    a = words[n_words-2];
                    if ((op == sme_pkg::OP_DIV || op == sme_pkg::OP_MOD) && b == 0)
                        st = sme_pkg::ST_DIVZ;
                    else begin
                        case (op)
                            sme_pkg::OP_ADD: r = a + b;
                            sme_pkg::OP_SUB: r = a - b;
                            sme_pkg::OP_MUL: r = a * b;
                            sme_pkg::OP_DIV: begin
                                r = mag(a) / mag(b);
                                if (a[31] != b[31]) r = -r;
                            end
                            default: begin
                                r = mag(a) % mag(b);
                                if (a[31]) r = -r;
                            end
                        endcase
                        words[n_words-2] = r;
                        n_words--;
                    end
                end
            end
            sme_pkg::OP_NOP: ;
            sme_pkg::OP_ROTL: begin
                if (n_words >= 2) begin
                    t = words[n_words-1];
                    for (i = n_words - 1; i > 0; i--) words[i] = words[i-1];
                    words[0] = t;
                end
            end
            sme_pkg::OP_ROTR: begin
                if (n_words >= 2) begin
                    t = words[0];
                    for (i = 0; i < n_words - 1; i++) words[i] = words[i+1];
                    words[n_words-1] = t;
                end
            end
            default: st = sme_pkg::ST_UNK;
        endcase
        pending.push_back(mk(st, 1'b0, 32'd0, 1'b1));
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (pending.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected result: status %0d value %h", o_status, o_value);
            end else begin
                e = pending.pop_front();
                if (o_status !== e.status || o_has_value !== e.has_value ||
                    o_value !== e.value || o_last !== e.last) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"mismatch: exp st %0d hv %0d val %h last %0d,",
                                  " got st %0d hv %0d val %h last %0d"},
                                 e.status, e.has_value, e.value, e.last,
                                 o_status, o_has_value, o_value, o_last);
                end
            end
        end
    end

    task automatic row(sme_pkg::t_op op, logic [31:0] v, logic typed = 1'b0,
                       sme_pkg::t_status s = sme_pkg::ST_OK);
        t_row r;
        r.op = op;
        r.operand = v;
        r.typed = typed;
        r.exp_status = s;
        table_rows.push_back(r);
    endtask

    // one command transfer; the bursty sender gap is left to gap()
    task automatic send(sme_pkg::t_op op, logic [31:0] v);
        i_command <= op;
        i_operand <= v;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        execute_cmd(op, v);
        n_cmds++;
    endtask

    task automatic gap();
        int g;
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            g = $urandom_range(1, 12);
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(1, 126);
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int           i, k;
        sme_pkg::t_op op;
        t_res         e;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = 4'd0;
        i_operand = 32'd0;
        n_words = 0;
        n_fail = 0;
        n_results = 0;
        n_cmds = 0;
        cycles = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // errors on an empty stack, then extremes of arithmetic
        row(sme_pkg::OP_PINT, 0, 1, sme_pkg::ST_EMPTY);
        row(sme_pkg::OP_POP, 0, 1, sme_pkg::ST_EMPTY);
        row(sme_pkg::OP_PCHAR, 0, 1, sme_pkg::ST_EMPTY);
        row(sme_pkg::OP_PALL, 0);
        row(sme_pkg::OP_BAD, 32'hFFFF_FFFF, 1, sme_pkg::ST_UNK);
        row(sme_pkg::OP_ROTL, 0, 1, sme_pkg::ST_OK);
        row(sme_pkg::OP_PUSH, 32'h8000_0000, 1, sme_pkg::ST_OK);
        row(sme_pkg::OP_SWAP, 0, 1, sme_pkg::ST_SHORT);
        row(sme_pkg::OP_ADD, 0, 1, sme_pkg::ST_SHORT);
        row(sme_pkg::OP_ROTR, 0, 1, sme_pkg::ST_OK);
        row(sme_pkg::OP_PUSH, 32'hFFFF_FFFF, 1, sme_pkg::ST_OK);
        row(sme_pkg::OP_DIV, 0);
        row(sme_pkg::OP_PUSH, 32'h8000_0000);
        row(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
        row(sme_pkg::OP_MOD, 0);
        row(sme_pkg::OP_PUSH, 0, 1, sme_pkg::ST_OK);
        row(sme_pkg::OP_DIV, 0, 1, sme_pkg::ST_DIVZ);
        row(sme_pkg::OP_MOD, 0, 1, sme_pkg::ST_DIVZ);
        row(sme_pkg::OP_PCHAR, 0);
        row(sme_pkg::OP_PUSH, 127);
        row(sme_pkg::OP_PCHAR, 0, 1, sme_pkg::ST_RANGE);
        row(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
        row(sme_pkg::OP_MUL, 0);
        row(sme_pkg::OP_SUB, 0);
        row(sme_pkg::OP_NOP, 0, 1, sme_pkg::ST_OK);

        foreach (table_rows[j]) begin
            send(table_rows[j].op, table_rows[j].operand);
            if (table_rows[j].typed && pending.size() > 0) begin
                e = pending[pending.size()-1];
                if (e.status != table_rows[j].exp_status) begin
                    n_fail++;
                    if (n_fail <= 10) $display("directed row %0d: model status %0d, table %0d",
                                              j, e.status, table_rows[j].exp_status);
                end
            end
            gap();
        end
        start <= 1'b0;
        while (pending.size() > 0) @(posedge i_clk);

        // fill to full, overflow, then list, rotate and drain
        for (i = 0; i < DEPTH + 2; i++)
            send(sme_pkg::OP_PUSH, i[0] ? rand_word() : $urandom_range(1, 126));
        send(sme_pkg::OP_PSTR, 0);
        send(sme_pkg::OP_PALL, 0);
        send(sme_pkg::OP_ROTL, 0);
        send(sme_pkg::OP_ROTR, 0);
        for (i = 0; i < DEPTH + 1; i++) send(sme_pkg::OP_POP, 0);
        start <= 1'b0;

        // random: pushes favoured, more so below two words, with bursts and gaps
        for (i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(0, 9);
            if (k < 4 || (n_words < 2 && k < 7)) op = sme_pkg::OP_PUSH;
            else op = sme_pkg::t_op'($urandom_range(0, 15));
            send(op, rand_word());
            gap();
        end
        start <= 1'b0;

        while (pending.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("%0d commands sent, %0d result items checked, stack depth %0d",
                 n_cmds, n_results, DEPTH);
        if (n_fail == 0 && pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
